### hw/rtl/gsst_pkg.sv
package gsst_pkg;

    localparam int MAX_GRID    = 1024;
    localparam int SAMPLE_BITS = 24;
    localparam int GRID_W      = 11;
    localparam int GRID_MIN    = 2;
    localparam int GRID_RESET  = 64;
    localparam int POS_W       = $clog2(MAX_GRID);
    localparam int LIN_W       = 2 * POS_W;
    localparam int PEND_W      = POS_W + 1;

    // weighted sum of nine cells, all weights add to 9
    localparam int DIVISOR   = 9;
    localparam int ROUND     = DIVISOR / 2;
    localparam int ACC_W     = SAMPLE_BITS + 4;
    localparam int DIV_SHIFT = ACC_W + 4;
    localparam int RECIP_W   = DIV_SHIFT - 3;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam int PROD_W    = ACC_W + RECIP_W;

    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = CQ_PTR_W + 1;
    localparam int OF_DEPTH = 8;
    localparam int OF_PTR_W = $clog2(OF_DEPTH);
    localparam int OF_CNT_W = OF_PTR_W + 1;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [POS_W-1:0]       t_pos;
    typedef logic [ACC_W-1:0]       t_acc;

    typedef enum logic [1:0] {
        WT_INNER  = 2'd0,
        WT_EDGE   = 2'd1,
        WT_CORNER = 2'd2
    } t_wt;

    typedef struct packed {
        logic    func;
        t_sample sample;
    } t_in_item;

    typedef struct packed {
        t_sample smoothed;
        logic    last_of_frame;
    } t_out_item;

    typedef struct packed {
        t_sample top;
        t_sample mid;
        t_sample bot;
    } t_col;

    typedef struct packed {
        logic produce;
        logic left_zero;
        logic right_zero;
        t_wt  wt;
        logic last;
        t_col col;
    } t_cmd;

endpackage

### hw/rtl/grid_3x3_smoothing_stencil.sv
// channel   direction  transfer when          payload
// input     in         push && !full          i_in_item   (func, sample)
// result    out        pop && !empty          o_out_item  (smoothed, last_of_frame)
// config    in         i_cfg_we               i_cfg_wdata (grid_size)
//
// One item per cycle sustained while full is low; the result for a cell follows the
// sample n+1 positions later, after the line RAM read, command queue, three-stage
// sum / reciprocal multiply and output queue.
// Reset clears control only; line RAMs are undefined until written.
// full rises only when the command queue, counting the command being read from
// the line RAMs, is out of room; the back end stalls on its own when the output queue plus its pipeline reaches eight.
module grid_3x3_smoothing_stencil import gsst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  t_in_item          i_in_item,
    output logic              empty,
    input  logic              pop,
    output t_out_item         o_out_item,
    input  logic              i_cfg_we,
    input  logic [GRID_W-1:0] i_cfg_wdata
);

    logic                cmd_valid, cq_valid, cq_pop;
    t_cmd                cmd, cq_data;
    logic [CQ_CNT_W-1:0] cq_count;

    gsst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cq_count  (cq_count),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    gsst_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  (cmd),
        .i_pop   (cq_pop),
        .o_valid (cq_valid),
        .o_data  (cq_data),
        .o_count (cq_count)
    );

    gsst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cq_valid),
        .i_cmd       (cq_data),
        .o_cmd_pop   (cq_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_item  (o_out_item)
    );

endmodule

### hw/rtl/gsst_ram.sv
module gsst_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/gsst_front.sv
module gsst_front import gsst_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  t_in_item            i_item,
    input  logic                i_cfg_we,
    input  logic [GRID_W-1:0]   i_cfg_wdata,
    input  logic [CQ_CNT_W-1:0] i_cq_count,
    output logic                o_cmd_valid,
    output t_cmd                o_cmd
);

    typedef logic [1:0] t_bank;

    typedef struct packed {
        logic    produce;
        logic    left_zero;
        logic    right_zero;
        t_wt     wt;
        logic    last;
        t_bank   top_sel;
        t_bank   mid_sel;
        logic    top_ok;
        logic    bot_ok;
        t_sample bot;
    } t_s1;

    function automatic t_bank bank_inc(input t_bank b);
        return (b == 2'd2) ? 2'd0 : t_bank'(b + 2'd1);
    endfunction

    function automatic t_bank bank_dec(input t_bank b);
        return (b == 2'd0) ? 2'd2 : t_bank'(b - 2'd1);
    endfunction

    logic [GRID_W-1:0] r_n, n_n;
    t_pos              r_in_col, n_in_col;
    t_pos              r_in_row, n_in_row;
    t_pos              r_out_col, n_out_col;
    t_pos              r_out_row, n_out_row;
    logic [LIN_W-1:0]  r_in_lin, n_in_lin;
    logic [PEND_W-1:0] r_pend, n_pend;
    t_bank             r_in_bank, n_in_bank;
    t_bank             r_out_bank, n_out_bank;
    logic              r_win_ok, n_win_ok;
    logic              r_s1_valid;
    t_s1               r_s1;
    t_s1               s1_nx;

    t_pos    nm1;
    logic    accept, is_smp, pend_full, produce, prime, issue, wrap;
    logic    out_last_col, out_last_row, in_last_col, in_last_row;
    logic    redge, cedge;
    t_pos    rd_addr, tgt_row;
    t_sample rdata [3];
    t_sample top_val, mid_val;
    logic [GRID_W-1:0] cfg_n;

    assign nm1          = t_pos'(r_n - GRID_W'(1));
    assign o_full       = (CQ_CNT_W+1)'(i_cq_count) + (CQ_CNT_W+1)'(r_s1_valid)
                          >= (CQ_CNT_W+1)'(CQ_DEPTH);
    assign accept       = i_push && !o_full;
    assign is_smp       = (i_item.func == FUNC_SAMPLE);
    assign pend_full    = (r_pend >= PEND_W'(r_n) + PEND_W'(1));
    assign produce      = is_smp ? pend_full : (LIN_W'(r_pend) > r_in_lin);
    assign prime        = is_smp && !pend_full && !r_win_ok && (r_pend == PEND_W'(r_n));
    assign issue        = accept && (produce || prime);
    assign out_last_col = (r_out_col == nm1);
    assign out_last_row = (r_out_row == nm1);
    assign in_last_col  = (r_in_col == nm1);
    assign in_last_row  = (r_in_row == nm1);
    assign wrap         = produce && out_last_col;
    assign redge        = (r_out_row == '0) || out_last_row;
    assign cedge        = (r_out_col == '0) || out_last_col;

    assign cfg_n = (i_cfg_wdata < GRID_W'(GRID_MIN)) ? GRID_W'(GRID_MIN) :
                   (i_cfg_wdata > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : i_cfg_wdata;

    // read column: right neighbor, column 0 of the next row, or current if no output
    always_comb begin
        if (wrap) begin
            rd_addr = '0;
            tgt_row = out_last_row ? '0 : t_pos'(r_out_row + t_pos'(1));
        end else if (produce) begin
            rd_addr = t_pos'(r_out_col + t_pos'(1));
            tgt_row = r_out_row;
        end else begin
            rd_addr = r_out_col;
            tgt_row = r_out_row;
        end
    end

    always_comb begin
        s1_nx.produce    = produce;
        s1_nx.left_zero  = (r_out_col == '0);
        s1_nx.right_zero = out_last_col;
        if (redge && cedge) begin
            s1_nx.wt = WT_CORNER;
        end else if (redge || cedge) begin
            s1_nx.wt = WT_EDGE;
        end else begin
            s1_nx.wt = WT_INNER;
        end
        s1_nx.last    = out_last_row && out_last_col;
        s1_nx.top_sel = wrap ? r_out_bank : bank_dec(r_out_bank);
        s1_nx.mid_sel = wrap ? bank_inc(r_out_bank) : r_out_bank;
        s1_nx.top_ok  = (tgt_row != '0);
        s1_nx.bot_ok  = (tgt_row != nm1);
        s1_nx.bot     = is_smp ? i_item.sample : '0;
    end

    for (genvar b = 0; b < 3; b++) begin : g_bank
        gsst_ram #(
            .WIDTH(SAMPLE_BITS),
            .DEPTH(MAX_GRID)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (accept && is_smp && (r_in_bank == t_bank'(b))),
            .i_waddr (r_in_col),
            .i_wdata (i_item.sample),
            .i_re    (issue),
            .i_raddr (rd_addr),
            .o_rdata (rdata[b])
        );
    end

    always_comb begin
        n_n        = r_n;
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_in_lin   = r_in_lin;
        n_in_bank  = r_in_bank;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_out_bank = r_out_bank;
        n_pend     = r_pend;
        n_win_ok   = r_win_ok;
        if (i_cfg_we) begin
            n_n        = cfg_n;
            n_in_col   = '0;
            n_in_row   = '0;
            n_in_lin   = '0;
            n_in_bank  = '0;
            n_out_col  = '0;
            n_out_row  = '0;
            n_out_bank = '0;
            n_pend     = '0;
            n_win_ok   = 1'b0;
        end else if (accept) begin
            if (produce) begin
                if (out_last_col) begin
                    n_out_col  = '0;
                    n_out_bank = bank_inc(r_out_bank);
                    n_out_row  = out_last_row ? '0 : t_pos'(r_out_row + t_pos'(1));
                end else begin
                    n_out_col = t_pos'(r_out_col + t_pos'(1));
                end
            end
            if (is_smp) begin
                if (!produce) begin
                    n_pend = r_pend + PEND_W'(1);
                end
                if (in_last_col) begin
                    n_in_col  = '0;
                    n_in_bank = bank_inc(r_in_bank);
                    n_in_row  = in_last_row ? '0 : t_pos'(r_in_row + t_pos'(1));
                end else begin
                    n_in_col = t_pos'(r_in_col + t_pos'(1));
                end
                n_in_lin = (in_last_col && in_last_row) ? '0 : r_in_lin + LIN_W'(1);
            end else if (produce) begin
                n_pend = r_pend - PEND_W'(1);
            end
            // a flush that closes a frame leaves column 0 of the next one unknown
            if (prime) begin
                n_win_ok = 1'b1;
            end else if (produce && !is_smp && out_last_col && out_last_row) begin
                n_win_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n        <= GRID_W'(GRID_RESET);
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_lin   <= '0;
            r_in_bank  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_bank <= '0;
            r_pend     <= '0;
            r_win_ok   <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_n        <= n_n;
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_in_lin   <= n_in_lin;
            r_in_bank  <= n_in_bank;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_out_bank <= n_out_bank;
            r_pend     <= n_pend;
            r_win_ok   <= n_win_ok;
            r_s1_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1 <= s1_nx;
        end
    end

    always_comb begin
        case (r_s1.top_sel)
            2'd0:    top_val = rdata[0];
            2'd1:    top_val = rdata[1];
            default: top_val = rdata[2];
        endcase
        case (r_s1.mid_sel)
            2'd0:    mid_val = rdata[0];
            2'd1:    mid_val = rdata[1];
            default: mid_val = rdata[2];
        endcase
    end

    assign o_cmd_valid      = r_s1_valid;
    assign o_cmd.produce    = r_s1.produce;
    assign o_cmd.left_zero  = r_s1.left_zero;
    assign o_cmd.right_zero = r_s1.right_zero;
    assign o_cmd.wt         = r_s1.wt;
    assign o_cmd.last       = r_s1.last;
    assign o_cmd.col.top    = r_s1.top_ok ? top_val : '0;
    assign o_cmd.col.mid    = mid_val;
    assign o_cmd.col.bot    = r_s1.bot_ok ? r_s1.bot : '0;

endmodule

### hw/rtl/gsst_cmdq.sv
module gsst_cmdq import gsst_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_cmd                i_data,
    input  logic                i_pop,
    output logic                o_valid,
    output t_cmd                o_data,
    output logic [CQ_CNT_W-1:0] o_count
);

    t_cmd                r_mem [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wr, r_rd;
    logic [CQ_CNT_W-1:0] r_count, n_count;
    logic                do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + CQ_CNT_W'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - CQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + CQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + CQ_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

### hw/rtl/gsst_back.sv
module gsst_back import gsst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_out_item
);

    function automatic t_acc col_sum(input t_col c);
        return ACC_W'(c.top) + ACC_W'(c.mid) + ACC_W'(c.bot);
    endfunction

    t_col                r_win_p, r_win_q;
    logic                r_b1_valid, r_b2_valid, r_b3_valid;
    t_acc                r_b1_lsum, r_b1_msum, r_b1_rsum;
    logic                r_b1_last, r_b2_last, r_b3_last;
    t_acc                r_b2_total;
    logic [PROD_W-1:0]   r_b3_prod;
    t_out_item           r_of_mem [OF_DEPTH];
    logic [OF_PTR_W-1:0] r_of_wr, r_of_rd;
    logic [OF_CNT_W-1:0] r_of_count, n_of_count;

    logic [OF_CNT_W:0]   occupancy;
    t_acc                lsum, msum, rsum, mid_w;
    logic                of_pop;
    t_out_item           of_wdata;

    // room for everything already in the pipe before taking another command
    assign occupancy = (OF_CNT_W+1)'(r_of_count) + (OF_CNT_W+1)'(r_b1_valid)
                     + (OF_CNT_W+1)'(r_b2_valid) + (OF_CNT_W+1)'(r_b3_valid);
    assign o_cmd_pop = i_cmd_valid && (occupancy < (OF_CNT_W+1)'(OF_DEPTH));

    always_comb begin
        case (i_cmd.wt)
            WT_INNER:  mid_w = ACC_W'(r_win_q.mid);
            WT_EDGE:   mid_w = ACC_W'(r_win_q.mid) << 2;
            WT_CORNER: mid_w = (ACC_W'(r_win_q.mid) << 2) + (ACC_W'(r_win_q.mid) << 1);
            default:   mid_w = ACC_W'(r_win_q.mid);
        endcase
        lsum = i_cmd.left_zero  ? '0 : col_sum(r_win_p);
        rsum = i_cmd.right_zero ? '0 : col_sum(i_cmd.col);
        msum = ACC_W'(r_win_q.top) + ACC_W'(r_win_q.bot) + mid_w;
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_win_p <= r_win_q;
            r_win_q <= i_cmd.col;
        end
        r_b1_lsum  <= lsum;
        r_b1_msum  <= msum;
        r_b1_rsum  <= rsum;
        r_b1_last  <= i_cmd.last;
        r_b2_total <= r_b1_lsum + r_b1_msum + r_b1_rsum + ACC_W'(ROUND);
        r_b2_last  <= r_b1_last;
        r_b3_prod  <= PROD_W'(r_b2_total) * PROD_W'(RECIP);
        r_b3_last  <= r_b2_last;
    end

    assign of_wdata.smoothed      = r_b3_prod[DIV_SHIFT +: SAMPLE_BITS];
    assign of_wdata.last_of_frame = r_b3_last;
    assign of_pop                 = i_pop && (r_of_count != '0);

    always_comb begin
        n_of_count = r_of_count;
        if (r_b3_valid && !of_pop) begin
            n_of_count = r_of_count + OF_CNT_W'(1);
        end else if (!r_b3_valid && of_pop) begin
            n_of_count = r_of_count - OF_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
            r_of_wr    <= '0;
            r_of_rd    <= '0;
            r_of_count <= '0;
        end else begin
            r_b1_valid <= o_cmd_pop && i_cmd.produce;
            r_b2_valid <= r_b1_valid;
            r_b3_valid <= r_b2_valid;
            if (r_b3_valid) begin
                r_of_wr <= r_of_wr + OF_PTR_W'(1);
            end
            if (of_pop) begin
                r_of_rd <= r_of_rd + OF_PTR_W'(1);
            end
            r_of_count <= n_of_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b3_valid) begin
            r_of_mem[r_of_wr] <= of_wdata;
        end
    end

    assign o_empty    = (r_of_count == '0);
    assign o_out_item = r_of_mem[r_of_rd];

endmodule
